// ----- hw/rtl/mfdf_pkg.sv -----
package mfdf_pkg;

   localparam int ID_W    = 8;
   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 4 * 8;
   localparam int LEN_W   = 7;
   localparam int MODE_W  = 2;

   localparam logic [LEN_W-1:0]  FRAME_BITS      = LEN_W'(4 * 8);
   localparam int                ID_LSB          = 3 * 8;
   localparam int                A_LSB           = 2 * 8;
   localparam int                B_LSB           = 1 * 8;

   localparam logic [MODE_W-1:0] LINK_MODE_RESET = 2'd3;
   localparam int                MODE_TX_BIT     = 0;
   localparam int                MODE_RX_BIT     = 1;

   localparam logic CMD_SEND    = 1'b0;
   localparam logic CMD_RECEIVE = 1'b1;

   localparam logic [1:0] STATUS_DELIVERED  = 2'd0;
   localparam logic [1:0] STATUS_NONE       = 2'd1;
   localparam logic [1:0] STATUS_BAD_LENGTH = 2'd2;

   typedef struct packed {
      logic              command;
      logic [ID_W-1:0]   msg_id;
      logic [BYTE_W-1:0] payload_a;
      logic [BYTE_W-1:0] payload_b;
      logic [BYTE_W-1:0] payload_c;
      logic [WORD_W-1:0] rx_word;
      logic [LEN_W-1:0]  rx_length;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              deliver_valid;
      logic [ID_W-1:0]   deliver_id;
      logic [BYTE_W-1:0] deliver_a;
      logic [BYTE_W-1:0] deliver_b;
      logic [BYTE_W-1:0] deliver_c;
      logic              tx_valid;
      logic [WORD_W-1:0] tx_word;
   } rsp_type;

   typedef struct packed {
      logic            en;
      logic [ID_W-1:0] id;
   } cache_wr_type;

endpackage

// ----- hw/rtl/mesh_flood_duplicate_filter.sv -----
// Flooding-mesh node core with a duplicate-suppression cache of recent IDs.
// Input channel req_valid/req_ready/req_data carries one transaction: either a
// local send (msg_id and three bytes) or a received radio frame (rx_word with
// its decoded bit length). Result channel rsp_valid/rsp_ready/rsp_data returns
// exactly one transaction per input: receive status, the delivered message if
// any, and the frame to transmit if any (send or forward).
// csr_we/csr_wdata write link_mode: bit 0 enables transmit, bit 1 receive.
// Write it only while the block is idle.
// Pipeline: an accepted transaction passes the input register, then the result
// register, before it shows on rsp. Throughput: one transaction per cycle while
// rsp is not stalled; the ID match over all cache entries and the ring update
// are combinational between the input register and the result register.
// Reset: clears all cache valid marks, the ring pointer and both stages, and
// sets link_mode to 3.
// When the receiver stalls, the result register holds; the input register
// still takes one more transaction, then req_ready drops until rsp drains.
module mesh_flood_duplicate_filter #(
   parameter int CACHE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mfdf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mfdf_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_wdata
);
   import mfdf_pkg::*;

   logic              in_valid_ff;
   req_type           in_data_ff;
   logic              out_valid_ff;
   rsp_type           out_data_ff;
   rsp_type           out_data_in;
   logic [MODE_W-1:0] link_mode_ff;
   logic              advance;
   logic              hit;
   logic [ID_W-1:0]   lookup_id;
   cache_wr_type      cache_wr;
   logic [ID_W-1:0]   rx_id;
   logic              do_tx;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign rx_id     = in_data_ff.rx_word[ID_LSB +: ID_W];
   assign lookup_id = (in_data_ff.command == CMD_SEND) ? in_data_ff.msg_id : rx_id;

   always_comb begin
      out_data_in = '0;
      do_tx       = 1'b0;
      if (in_data_ff.command == CMD_SEND) begin
         out_data_in.status = STATUS_NONE;
         if (link_mode_ff[MODE_TX_BIT]) begin
            do_tx = 1'b1;
            out_data_in.tx_word = {in_data_ff.msg_id, in_data_ff.payload_a,
                                   in_data_ff.payload_b, in_data_ff.payload_c};
         end
      end else if (!link_mode_ff[MODE_RX_BIT]) begin
         out_data_in.status = STATUS_NONE;
      end else if (in_data_ff.rx_length != FRAME_BITS) begin
         out_data_in.status = STATUS_BAD_LENGTH;
      end else if (hit) begin
         out_data_in.status = STATUS_NONE;
      end else begin
         out_data_in.status        = STATUS_DELIVERED;
         out_data_in.deliver_valid = 1'b1;
         out_data_in.deliver_id    = rx_id;
         out_data_in.deliver_a     = in_data_ff.rx_word[A_LSB +: BYTE_W];
         out_data_in.deliver_b     = in_data_ff.rx_word[B_LSB +: BYTE_W];
         out_data_in.deliver_c     = in_data_ff.rx_word[BYTE_W-1:0];
         if (link_mode_ff[MODE_TX_BIT]) begin
            do_tx = 1'b1;
            out_data_in.tx_word = in_data_ff.rx_word;
         end
      end
      out_data_in.tx_valid = do_tx;
   end

   assign cache_wr.en = in_valid_ff && advance && do_tx;
   assign cache_wr.id = lookup_id;

   mfdf_cache #(
      .DEPTH(CACHE_DEPTH)
   ) u_cache (
      .clock    (clock),
      .reset    (reset),
      .wr       (cache_wr),
      .lookup_id(lookup_id),
      .hit      (hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         link_mode_ff <= LINK_MODE_RESET;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (csr_we) begin
            link_mode_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
      if (advance && in_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

`ifndef SYNTHESIS
   a_deliver_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.deliver_valid) |-> rsp_data.status == STATUS_DELIVERED)
      else $error("delivery without delivered status");

   a_forward_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.deliver_valid && rsp_data.tx_valid) |->
      rsp_data.tx_word == {rsp_data.deliver_id, rsp_data.deliver_a,
                           rsp_data.deliver_b, rsp_data.deliver_c})
      else $error("forwarded frame differs from delivered message");

   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff && $stable(in_data_ff))
      else $error("input stage lost a transaction during stall");

   a_cache_write_only_on_tx: assert property (@(posedge clock) disable iff (reset)
      cache_wr.en |-> (in_valid_ff && link_mode_ff[MODE_TX_BIT]))
      else $error("cache written without transmit");
`endif

endmodule

// ----- hw/rtl/mfdf_cache.sv -----
module mfdf_cache #(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mfdf_pkg::cache_wr_type wr,
   input  logic [7:0]            lookup_id,
   output logic                  hit
);
   import mfdf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [ID_W-1:0]  ids_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic [PTR_W-1:0] ptr_ff;
   logic [PTR_W-1:0] ptr_in;
   logic             write_fire;

   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         if (valid_ff[i] && ids_ff[i] == lookup_id) begin
            hit = 1'b1;
         end
      end
   end

   // skip recording an ID already held in the ring
   assign write_fire = wr.en && !hit;

   always_comb begin
      valid_in = valid_ff;
      ptr_in   = ptr_ff;
      if (write_fire) begin
         valid_in[ptr_ff] = 1'b1;
         ptr_in = (ptr_ff == LAST) ? '0 : ptr_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_fire) begin
         ids_ff[ptr_ff] <= wr.id;
      end
   end

endmodule

// ----- tb/mesh_flood_duplicate_filter_test.sv -----
module mesh_flood_duplicate_filter_test;
   import mfdf_pkg::*;

   localparam int CACHE_SLOTS   = 16;
   localparam int IDLE_PCT      = 32;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 4;
   localparam int LONG_HOLD     = 80;
   localparam int PHASES        = 5;

   class relay_scoreboard;
      logic [MODE_W-1:0] link_mode;
      logic [ID_W-1:0]   ring_id [CACHE_SLOTS];
      bit                ring_live [CACHE_SLOTS];
      int                ring_head;
      rsp_type           awaited_results [$];
      int                failures;

      function new();
         link_mode = LINK_MODE_RESET;
         ring_head = 0;
         failures  = 0;
         foreach (ring_id[i]) begin
            ring_id[i]   = '0;
            ring_live[i] = 1'b0;
         end
      endfunction

      function bit id_seen(logic [ID_W-1:0] id);
         foreach (ring_id[i])
            if (ring_live[i] && ring_id[i] == id) return 1'b1;
         return 1'b0;
      endfunction

      function void relay_frame(logic [ID_W-1:0] id, logic [BYTE_W-1:0] a,
                                logic [BYTE_W-1:0] b, logic [BYTE_W-1:0] c,
                                inout rsp_type r);
         if (!link_mode[MODE_TX_BIT]) return;
         r.tx_valid = 1'b1;
         r.tx_word  = {id, a, b, c};
         if (!id_seen(id)) begin
            ring_id[ring_head]   = id;
            ring_live[ring_head] = 1'b1;
            ring_head            = (ring_head + 1) % CACHE_SLOTS;
         end
      endfunction

      function rsp_type forecast(req_type q);
         rsp_type         r;
         logic [ID_W-1:0] id;
         r  = '0;
         id = q.rx_word[ID_LSB +: ID_W];
         if (q.command == CMD_SEND) begin
            r.status = STATUS_NONE;
            relay_frame(q.msg_id, q.payload_a, q.payload_b, q.payload_c, r);
         end else if (!link_mode[MODE_RX_BIT]) begin
            r.status = STATUS_NONE;
         end else if (q.rx_length != FRAME_BITS) begin
            r.status = STATUS_BAD_LENGTH;
         end else if (id_seen(id)) begin
            r.status = STATUS_NONE;
         end else begin
            r.status        = STATUS_DELIVERED;
            r.deliver_valid = 1'b1;
            r.deliver_id    = id;
            r.deliver_a     = q.rx_word[A_LSB +: BYTE_W];
            r.deliver_b     = q.rx_word[B_LSB +: BYTE_W];
            r.deliver_c     = q.rx_word[BYTE_W-1:0];
            relay_frame(id, r.deliver_a, r.deliver_b, r.deliver_c, r);
         end
         return r;
      endfunction

      function void note_request(req_type q);
         awaited_results.push_back(forecast(q));
      endfunction

      function string show(rsp_type r);
         return $sformatf("status=%0d dv=%0b id=%h a=%h b=%h c=%h tx=%0b word=%h",
                          r.status, r.deliver_valid, r.deliver_id, r.deliver_a,
                          r.deliver_b, r.deliver_c, r.tx_valid, r.tx_word);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited_results.size() == 0) begin
            failures++;
            if (failures <= 10) $display("unexpected response: %s", show(got));
            return;
         end
         want = awaited_results.pop_front();
         if (got.status !== want.status || got.deliver_valid !== want.deliver_valid ||
             got.deliver_id !== want.deliver_id || got.deliver_a !== want.deliver_a ||
             got.deliver_b !== want.deliver_b || got.deliver_c !== want.deliver_c ||
             got.tx_valid !== want.tx_valid || got.tx_word !== want.tx_word) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: expected %s, actual %s", show(want), show(got));
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              csr_we;
   logic [MODE_W-1:0] csr_wdata;

   relay_scoreboard sb;
   bit              steady;
   bit              stall_wanted;
   int              stall_left;
   int              quiet_cycles;
   int              mode_plan [PHASES] = '{1, 2, 0, 3, 3};
   int              phase_len [PHASES] = '{250, 250, 150, 450, 400};

   mesh_flood_duplicate_filter #(
      .CACHE_DEPTH(CACHE_SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      rsp_ready  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_wanted) begin
            stall_wanted = 1'b0;
            stall_left   = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   function logic [ID_W-1:0] pick_id();
      if ($urandom_range(99) < 65) return ID_W'($urandom_range(23));
      return ID_W'($urandom_range(255));
   endfunction

   function req_type random_request();
      req_type q;
      q.command   = 1'($urandom_range(1));
      q.msg_id    = pick_id();
      q.payload_a = BYTE_W'($urandom);
      q.payload_b = BYTE_W'($urandom);
      q.payload_c = BYTE_W'($urandom);
      q.rx_word   = $urandom;
      q.rx_word[ID_LSB +: ID_W] = pick_id();
      q.rx_length = ($urandom_range(99) < 85) ? FRAME_BITS : LEN_W'($urandom_range(127));
      return q;
   endfunction

   function req_type make_send(logic [ID_W-1:0] id, logic [BYTE_W-1:0] a,
                               logic [BYTE_W-1:0] b, logic [BYTE_W-1:0] c);
      req_type q;
      q           = '0;
      q.command   = CMD_SEND;
      q.msg_id    = id;
      q.payload_a = a;
      q.payload_b = b;
      q.payload_c = c;
      return q;
   endfunction

   function req_type make_frame(logic [WORD_W-1:0] word, logic [LEN_W-1:0] len);
      req_type q;
      q           = '0;
      q.command   = CMD_RECEIVE;
      q.rx_word   = word;
      q.rx_length = len;
      return q;
   endfunction

   task automatic offer(req_type q);
      @(negedge clock);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_link_mode(logic [MODE_W-1:0] mode);
      drain();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.link_mode = mode;
   endtask

   initial begin
      sb           = new();
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      steady       = 1'b0;
      stall_wanted = 1'b0;
      quiet_cycles = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // ID 0 must not hit the empty ring
      offer(make_frame(32'h0000_0000, FRAME_BITS));
      offer(make_frame(32'h0011_2233, FRAME_BITS));
      offer(make_send(8'hFF, 8'hFF, 8'hFF, 8'hFF));
      offer(make_frame(32'hFF12_3456, FRAME_BITS));
      offer(make_send(8'hFF, 8'h00, 8'h00, 8'h00));
      offer(make_frame(32'hABCD_EF01, 7'd0));
      offer(make_frame(32'hABCD_EF01, 7'd31));
      offer(make_frame(32'hABCD_EF01, 7'd33));
      offer(make_frame(32'hABCD_EF01, 7'd64));
      offer(make_frame(32'hABCD_EF01, 7'd127));
      offer(make_frame(32'hA55A_C33C, FRAME_BITS));
      offer(make_frame(32'hA500_0000, FRAME_BITS));
      offer(make_send(8'h00, 8'h00, 8'h00, 8'h00));
      offer(make_send(8'h80, 8'h01, 8'h02, 8'h03));
      offer(make_frame(32'hFFFF_FFFF, FRAME_BITS));

      for (int p = 0; p < PHASES; p++) begin
         set_link_mode(MODE_W'(mode_plan[p]));
         if (p == 3) begin
            steady       = 1'b1;
            stall_wanted = 1'b1;
         end
         repeat (phase_len[p]) offer(random_request());
         steady = 1'b0;
      end

      drain();
      if (sb.failures == 0 && sb.awaited_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
